// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define C3ZP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// condition must never be seen at a clock edge out of reset
`define C3ZP_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`endif

// File: rtl/core/c3zp_pkg.sv
// ----------------------------------------------------------------------------
// c3zp_pkg
// Widths, register codes, reset values and shared types of the 3x3 filter.
// ----------------------------------------------------------------------------
package c3zp_pkg;

  localparam int PIX_W          = 16;
  localparam int COEF_W         = 16;
  localparam int PROD_W         = PIX_W + COEF_W;
  localparam int COL_SUM_W      = PROD_W + 2;
  localparam int TOTAL_W        = COL_SUM_W + 2;
  localparam int RESULT_W       = 32;
  localparam int FRAC_W         = 8;
  localparam int LINE_W         = 2 * PIX_W;

  localparam int FRAME_WIDTH_W  = 11;
  localparam int FRAME_HEIGHT_W = 9;
  localparam int KERNEL_ROW_W   = 3 * COEF_W;
  localparam int APB_DATA_W     = 64;
  localparam int APB_ADDR_W     = 6;
  localparam int REG_IDX_W      = 3;

  localparam int DEF_MAX_LINE_WIDTH   = 1024;
  localparam int DEF_MAX_FRAME_HEIGHT = 256;

  localparam int QUEUE_DEPTH    = 8;
  localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KERNEL_TOP   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_KERNEL_MID   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_KERNEL_BOT   = 3'd4;

  localparam logic [FRAME_WIDTH_W-1:0]  RST_FRAME_WIDTH  = 11'd1024;
  localparam logic [FRAME_HEIGHT_W-1:0] RST_FRAME_HEIGHT = 9'd256;
  localparam logic [KERNEL_ROW_W-1:0]   RST_KERNEL_MID   = 48'd256;

  // one window column, index 0 is the oldest row
  typedef logic [2:0][PIX_W-1:0]  pix_col_t;
  typedef logic [2:0][COEF_W-1:0] coef_col_t;

  typedef struct packed {
    logic                last;
    logic [RESULT_W-1:0] value;
  } result_t;

endpackage

// File: rtl/core/c3zp_line_store.sv
// ----------------------------------------------------------------------------
// c3zp_line_store
// Two line buffers packed in one word per column, registered read port.
// ----------------------------------------------------------------------------
module c3zp_line_store #(
  parameter int DEPTH = c3zp_pkg::DEF_MAX_LINE_WIDTH
) (
  input  logic                              clk,
  input  logic                              rd_en,
  input  logic [$clog2(DEPTH)-1:0]          rd_addr,
  output logic [c3zp_pkg::LINE_W-1:0]       rd_data,
  input  logic                              wr_en,
  input  logic [$clog2(DEPTH)-1:0]          wr_addr,
  input  logic [c3zp_pkg::LINE_W-1:0]       wr_data
);
  import c3zp_pkg::*;

  logic [LINE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/c3zp_window_cell.sv
// ----------------------------------------------------------------------------
// c3zp_window_cell
// One column of the 3x3 window: shifts in its neighbor's column, weights
// its three pixels and sums them into a column partial sum.
// ----------------------------------------------------------------------------
module c3zp_window_cell (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  shift,
  input  c3zp_pkg::pix_col_t                    col_in,
  output c3zp_pkg::pix_col_t                    col_out,
  input  c3zp_pkg::coef_col_t                   coef,
  output logic signed [c3zp_pkg::COL_SUM_W-1:0] col_sum
);
  import c3zp_pkg::*;

  pix_col_t                 col;
  logic signed [PROD_W-1:0] prod [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
    end else if (shift) begin
      col <= col_in;
    end
  end

  assign col_out = col;

  // drop pixels under a zero weight
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      prod[i] <= $signed((coef[i] == '0) ? {PIX_W{1'b0}} : col[i]) * $signed(coef[i]);
    end
    col_sum <= COL_SUM_W'(prod[0]) + COL_SUM_W'(prod[1]) + COL_SUM_W'(prod[2]);
  end

endmodule

// File: rtl/core/c3zp_result_fifo.sv
// ----------------------------------------------------------------------------
// c3zp_result_fifo
// Output queue that decouples the filter pipeline from the result consumer.
// ----------------------------------------------------------------------------
module c3zp_result_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  c3zp_pkg::result_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output c3zp_pkg::result_t pop_data
);
  import c3zp_pkg::*;

  result_t                slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   pop;

  assign pop_valid = (count != '0);
  assign pop_data  = slots[rd_ptr];
  assign pop       = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/core/conv3x3_zero_pad_filter.sv
// Path: issue slot, window and coefficient registers, products, column sums,
// total, then the output queue. Throughput: one pixel per cycle while the queue
// has credit; a pixel that closes a row or lies in the last row holds in_ready low
// until each result it releases has passed the single issue slot to the queue.
// Reset (rst, synchronous): counters, window and queue clear, registers take
// their defaults; the line store is not cleared.
// ----------------------------------------------------------------------------
// conv3x3_zero_pad_filter
// Raster-stream 3x3 convolution with zero padding, Q8.8 kernel, APB config.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module conv3x3_zero_pad_filter #(
  parameter int MAX_LINE_WIDTH   = c3zp_pkg::DEF_MAX_LINE_WIDTH,
  parameter int MAX_FRAME_HEIGHT = c3zp_pkg::DEF_MAX_FRAME_HEIGHT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [c3zp_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [c3zp_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [c3zp_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [c3zp_pkg::PIX_W-1:0]    pixel_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [c3zp_pkg::RESULT_W-1:0] filtered_value,
  output logic                                 frame_end
);
  import c3zp_pkg::*;

  localparam int CW = $clog2(MAX_LINE_WIDTH);
  localparam int RW = $clog2(MAX_FRAME_HEIGHT);

  // configuration registers
  logic [FRAME_WIDTH_W-1:0]  frame_width;
  logic [FRAME_HEIGHT_W-1:0] frame_height;
  logic [KERNEL_ROW_W-1:0]   kern_row [3];
  logic                      cfg_wr;
  logic [REG_IDX_W-1:0]      cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
      kern_row[0]  <= '0;
      kern_row[1]  <= RST_KERNEL_MID;
      kern_row[2]  <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FRAME_WIDTH:  frame_width  <= pwdata[FRAME_WIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[FRAME_HEIGHT_W-1:0];
        REG_KERNEL_TOP:   kern_row[0]  <= pwdata[KERNEL_ROW_W-1:0];
        REG_KERNEL_MID:   kern_row[1]  <= pwdata[KERNEL_ROW_W-1:0];
        REG_KERNEL_BOT:   kern_row[2]  <= pwdata[KERNEL_ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width);
      REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height);
      REG_KERNEL_TOP:   prdata = APB_DATA_W'(kern_row[0]);
      REG_KERNEL_MID:   prdata = APB_DATA_W'(kern_row[1]);
      REG_KERNEL_BOT:   prdata = APB_DATA_W'(kern_row[2]);
      default:          prdata = '0;
    endcase
  end

  // effective frame size, zero acts as one and oversize as the maximum
  logic [31:0]   col_last32;
  logic [31:0]   row_last32;
  logic [CW-1:0] col_last;
  logic [RW-1:0] row_last;

  always_comb begin
    if (frame_width == '0) begin
      col_last32 = '0;
    end else if (32'(frame_width) > 32'(MAX_LINE_WIDTH)) begin
      col_last32 = 32'(MAX_LINE_WIDTH - 1);
    end else begin
      col_last32 = 32'(frame_width) - 32'd1;
    end
    if (frame_height == '0) begin
      row_last32 = '0;
    end else if (32'(frame_height) > 32'(MAX_FRAME_HEIGHT)) begin
      row_last32 = 32'(MAX_FRAME_HEIGHT - 1);
    end else begin
      row_last32 = 32'(frame_height) - 32'd1;
    end
  end

  assign col_last = col_last32[CW-1:0];
  assign row_last = row_last32[RW-1:0];

  // position counters
  logic [CW-1:0] col_cnt;
  logic [RW-1:0] row_cnt;
  logic [CW-1:0] c_fresh;
  logic [RW-1:0] r_fresh;
  logic          at_last_col;
  logic          at_last_row;
  logic          accept;

  assign c_fresh     = (col_cnt > col_last) ? col_last : col_cnt;
  assign r_fresh     = (row_cnt > row_last) ? row_last : row_cnt;
  assign at_last_col = (c_fresh == col_last);
  assign at_last_row = (r_fresh == row_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      if (at_last_col) begin
        col_cnt <= '0;
        row_cnt <= at_last_row ? '0 : r_fresh + 1'b1;
      end else begin
        col_cnt <= c_fresh + 1'b1;
      end
    end
  end

  // result issue sequencer: results in order (r-1,c-1) (r-1,c) (r,c-1) (r,c)
  logic [3:0]             fresh_mask;
  logic [3:0]             pend;
  logic [3:0]             src_mask;
  logic [3:0]             pick;
  logic [1:0]             pick_idx;
  logic                   pick_any;
  logic                   fresh_r1, fresh_r2, fresh_c1, fresh_c2;
  logic                   hold_r1, hold_r2, hold_c1, hold_c2;
  logic                   src_r1, src_r2, src_c1, src_c2;
  logic [QUEUE_CNT_W-1:0] outstanding;
  logic                   credit_ok;
  logic                   issue;
  logic                   pop;

  assign fresh_r1 = (r_fresh != '0);
  assign fresh_r2 = (r_fresh > RW'(1));
  assign fresh_c1 = (c_fresh != '0);
  assign fresh_c2 = (c_fresh > CW'(1));

  assign fresh_mask[0] = fresh_r1 && fresh_c1;
  assign fresh_mask[1] = fresh_r1 && at_last_col;
  assign fresh_mask[2] = at_last_row && fresh_c1;
  assign fresh_mask[3] = at_last_row && at_last_col;

  assign credit_ok = (outstanding < QUEUE_CNT_W'(QUEUE_DEPTH));
  assign in_ready  = (pend == '0) && credit_ok;
  assign accept    = in_valid && in_ready;
  assign issue     = accept || ((pend != '0) && credit_ok);

  assign src_mask = accept ? fresh_mask : pend;
  assign src_r1   = accept ? fresh_r1 : hold_r1;
  assign src_r2   = accept ? fresh_r2 : hold_r2;
  assign src_c1   = accept ? fresh_c1 : hold_c1;
  assign src_c2   = accept ? fresh_c2 : hold_c2;

  always_comb begin
    pick_idx = 2'd0;
    pick     = 4'b0000;
    pick_any = 1'b1;
    if (src_mask[0]) begin
      pick_idx = 2'd0;
      pick     = 4'b0001;
    end else if (src_mask[1]) begin
      pick_idx = 2'd1;
      pick     = 4'b0010;
    end else if (src_mask[2]) begin
      pick_idx = 2'd2;
      pick     = 4'b0100;
    end else if (src_mask[3]) begin
      pick_idx = 2'd3;
      pick     = 4'b1000;
    end else begin
      pick_any = 1'b0;
    end
  end

  // issue slot
  logic          slot_valid;
  logic          slot_shift;
  logic          slot_emit;
  logic          slot_last;
  logic          slot_a;
  logic          slot_b;
  logic [2:0]    slot_row_ok;
  logic [2:0]    slot_col_ok;
  logic [PIX_W-1:0] slot_pix;
  logic [CW-1:0] slot_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend       <= '0;
      slot_valid <= 1'b0;
    end else begin
      slot_valid <= issue;
      if (issue) begin
        pend <= src_mask & ~pick;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r1  <= fresh_r1;
      hold_r2  <= fresh_r2;
      hold_c1  <= fresh_c1;
      hold_c2  <= fresh_c2;
      slot_pix <= pixel_in;
      slot_col <= c_fresh;
    end
    if (issue) begin
      slot_shift     <= accept;
      slot_emit      <= pick_any;
      slot_a         <= pick_idx[1];
      slot_b         <= pick_idx[0];
      slot_last      <= pick_any && (pick_idx == 2'd3);
      slot_row_ok[0] <= src_r2 && !pick_idx[1];
      slot_row_ok[1] <= src_r1;
      slot_row_ok[2] <= 1'b1;
      slot_col_ok[0] <= src_c2 && !pick_idx[0];
      slot_col_ok[1] <= src_c1;
      slot_col_ok[2] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      case ({issue && pick_any, pop})
        2'b10:   outstanding <= outstanding + 1'b1;
        2'b01:   outstanding <= outstanding - 1'b1;
        default: outstanding <= outstanding;
      endcase
    end
  end

  // line store with forwarding for back-to-back access to one column
  logic [LINE_W-1:0] mem_dout;
  logic [LINE_W-1:0] rd_eff;
  logic [LINE_W-1:0] wr_data;
  logic [LINE_W-1:0] fwd_data;
  logic              fwd_hit;
  logic              win_shift;

  assign win_shift = slot_valid && slot_shift;
  assign rd_eff    = fwd_hit ? fwd_data : mem_dout;
  assign wr_data   = {slot_pix, rd_eff[LINE_W-1:PIX_W]};

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= accept && win_shift && (slot_col == c_fresh);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= wr_data;
  end

  c3zp_line_store #(
    .DEPTH(MAX_LINE_WIDTH)
  ) u_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (c_fresh),
    .rd_data (mem_dout),
    .wr_en   (win_shift),
    .wr_addr (slot_col),
    .wr_data (wr_data)
  );

  // coefficient alignment for the selected result
  logic [KERNEL_ROW_W-1:0] row_src [3];
  coef_col_t               coef_next [3];
  coef_col_t               coef_b [3];

  always_comb begin
    row_src[0] = slot_a ? '0 : kern_row[0];
    row_src[1] = slot_a ? kern_row[0] : kern_row[1];
    row_src[2] = slot_a ? kern_row[1] : kern_row[2];
    for (int wr = 0; wr < 3; wr++) begin
      coef_next[0][wr] = (slot_row_ok[wr] && slot_col_ok[0] && !slot_b) ?
                         row_src[wr][COEF_W-1:0] : '0;
      coef_next[1][wr] = (slot_row_ok[wr] && slot_col_ok[1]) ?
                         (slot_b ? row_src[wr][COEF_W-1:0] :
                                   row_src[wr][2*COEF_W-1:COEF_W]) : '0;
      coef_next[2][wr] = (slot_row_ok[wr] && slot_col_ok[2]) ?
                         (slot_b ? row_src[wr][2*COEF_W-1:COEF_W] :
                                   row_src[wr][3*COEF_W-1:2*COEF_W]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      coef_b[k] <= coef_next[k];
    end
  end

  // window chain: cell 2 takes the new column, each cell feeds its left neighbor
  pix_col_t                    chain [4];
  logic signed [COL_SUM_W-1:0] cell_sum [3];

  assign chain[3][0] = rd_eff[PIX_W-1:0];
  assign chain[3][1] = rd_eff[LINE_W-1:PIX_W];
  assign chain[3][2] = slot_pix;

  genvar k;
  for (k = 0; k < 3; k++) begin : g_cell
    c3zp_window_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .shift   (win_shift),
      .col_in  (chain[k+1]),
      .col_out (chain[k]),
      .coef    (coef_b[k]),
      .col_sum (cell_sum[k])
    );
  end

  // result pipeline
  logic                      v_b, v_c, v_d, v_e;
  logic                      last_b, last_c, last_d, last_e;
  logic signed [TOTAL_W-1:0] total;
  logic signed [TOTAL_W-1:0] rounded;
  logic signed [TOTAL_W-1:0] shifted;
  result_t                   push_data;
  result_t                   pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_b <= 1'b0;
      v_c <= 1'b0;
      v_d <= 1'b0;
      v_e <= 1'b0;
    end else begin
      v_b <= slot_valid && slot_emit;
      v_c <= v_b;
      v_d <= v_c;
      v_e <= v_d;
    end
  end

  always_ff @(posedge clk) begin
    last_b <= slot_last;
    last_c <= last_b;
    last_d <= last_c;
    last_e <= last_d;
    total  <= TOTAL_W'(cell_sum[0]) + TOTAL_W'(cell_sum[1]) + TOTAL_W'(cell_sum[2]);
  end

  // drop the fraction toward zero
  assign rounded = total + $signed({{(TOTAL_W-FRAC_W){1'b0}}, {FRAC_W{total[TOTAL_W-1]}}});
  assign shifted = rounded >>> FRAC_W;

  assign push_data.last  = last_e;
  assign push_data.value = shifted[RESULT_W-1:0];

  c3zp_result_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (v_e),
    .push_data (push_data),
    .pop_valid (out_valid),
    .pop_ready (out_ready),
    .pop_data  (pop_data)
  );

  assign pop            = out_valid && out_ready;
  assign filtered_value = $signed(pop_data.value);
  assign frame_end      = pop_data.last;

  `C3ZP_ASSERT_NEVER(a_credit_bound, outstanding > QUEUE_CNT_W'(QUEUE_DEPTH))
  `C3ZP_ASSERT(a_accept_shifts, (in_valid && in_ready) |=> (slot_valid && slot_shift))
  `C3ZP_ASSERT(a_push_counted, v_e |-> (outstanding != '0))

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 3x3 zero-padded convolution filter. Pixels go in
// through a valid/ready driver fed from a queue and registers through APB
// writes. A line-buffer model computes the expected filtered values and
// frame-end flags at each pixel transaction, and a monitor compares every
// output transaction in order. The run covers directed corner frames,
// oversized size registers and random frames with mid-frame size and kernel
// changes.
// ----------------------------------------------------------------------------
module tb_top;
  import c3zp_pkg::*;

  localparam int LINE_MAX     = DEF_MAX_LINE_WIDTH;
  localparam int ROWS_MAX     = DEF_MAX_FRAME_HEIGHT;
  localparam int SETTLE       = 16;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 140;

  typedef struct {
    logic signed [RESULT_W-1:0] value;
    logic                       last;
  } filt_result_t;

  logic                       clk     = 1'b0;
  logic                       rst     = 1'b1;
  logic                       psel    = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0]      paddr   = '0;
  logic [APB_DATA_W-1:0]      pwdata  = '0;
  logic [APB_DATA_W-1:0]      prdata;
  logic                       pready;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [PIX_W-1:0]    pixel_in = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [RESULT_W-1:0] filtered_value;
  logic                       frame_end;

  // filter model state
  logic [FRAME_WIDTH_W-1:0]  cfg_width  = RST_FRAME_WIDTH;
  logic [FRAME_HEIGHT_W-1:0] cfg_height = RST_FRAME_HEIGHT;
  logic [KERNEL_ROW_W-1:0]   cfg_kernel [3] = '{'0, RST_KERNEL_MID, '0};
  logic signed [PIX_W-1:0]   line_mem [2][LINE_MAX] = '{default: '0};
  logic signed [PIX_W-1:0]   win [3][3] = '{default: '0};
  int                        col_pos = 0;
  int                        row_pos = 0;

  logic signed [PIX_W-1:0] pixel_queue [$];
  filt_result_t            expected_results [$];

  int   pixels_pushed   = 0;
  int   pixels_accepted = 0;
  int   results_seen    = 0;
  int   frames_seen     = 0;
  int   reg_writes      = 0;
  int   error_count     = 0;
  int   cycle_count     = 0;
  int   in_gap          = 0;
  int   out_stall       = 0;
  logic pix_taken       = 1'b0;
  logic burst_mode      = 1'b0;

  conv3x3_zero_pad_filter i_dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .pixel_in       (pixel_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .filtered_value (filtered_value),
    .frame_end      (frame_end)
  );

  always #6 clk = ~clk;

  function automatic int eff_width();
    int w;
    w = (cfg_width == 0) ? 1 : int'(cfg_width);
    if (w > LINE_MAX) w = LINE_MAX;
    return w;
  endfunction

  function automatic int eff_height();
    int h;
    h = (cfg_height == 0) ? 1 : int'(cfg_height);
    if (h > ROWS_MAX) h = ROWS_MAX;
    return h;
  endfunction

  function automatic longint window_sum(int y, int x, int r, int c, int w, int h);
    longint                   acc;
    int                       py, px, wr, wc;
    logic signed [COEF_W-1:0] coef;
    acc = 0;
    for (int ky = 0; ky < 3; ky++) begin
      for (int kx = 0; kx < 3; kx++) begin
        py = y + ky - 1;
        px = x + kx - 1;
        wr = py - (r - 2);
        wc = px - (c - 2);
        if (py >= 0 && py < h && px >= 0 && px < w &&
            wr >= 0 && wr <= 2 && wc >= 0 && wc <= 2) begin
          coef = cfg_kernel[ky][COEF_W*kx +: COEF_W];
          acc += longint'(win[wr][wc]) * longint'(coef);
        end
      end
    end
    return acc / 256;
  endfunction

  function automatic void filter_pixel(logic signed [PIX_W-1:0] pix);
    int           w, h, r, c, y, x;
    longint       q;
    filt_result_t rec;
    w = eff_width();
    h = eff_height();
    if (col_pos >= w) col_pos = w - 1;
    if (row_pos >= h) row_pos = h - 1;
    r = row_pos;
    c = col_pos;
    for (int a = 0; a < 3; a++) begin
      win[a][0] = win[a][1];
      win[a][1] = win[a][2];
    end
    win[0][2] = line_mem[0][c];
    win[1][2] = line_mem[1][c];
    win[2][2] = pix;
    line_mem[0][c] = line_mem[1][c];
    line_mem[1][c] = pix;
    for (int a = 0; a < 2; a++) begin
      if (a == 0 ? (r >= 1) : (r == h - 1)) begin
        for (int b = 0; b < 2; b++) begin
          if (b == 0 ? (c >= 1) : (c == w - 1)) begin
            y = r - 1 + a;
            x = c - 1 + b;
            q = window_sum(y, x, r, c, w, h);
            rec.value = q[RESULT_W-1:0];
            rec.last  = (y == h - 1 && x == w - 1);
            expected_results.push_back(rec);
          end
        end
      end
    end
    if (c == w - 1) begin
      col_pos = 0;
      row_pos = (r == h - 1) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (burst_mode || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic logic signed [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 19))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  function automatic logic [KERNEL_ROW_W-1:0] rand_kernel();
    logic [KERNEL_ROW_W-1:0] k;
    int                      sel;
    sel = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      case (sel)
        0: k[COEF_W*i +: COEF_W] = 16'h8000;
        1: k[COEF_W*i +: COEF_W] = 16'h7FFF;
        2, 3, 4: k[COEF_W*i +: COEF_W] = COEF_W'($signed($urandom_range(0, 1024)) - 512);
        default: k[COEF_W*i +: COEF_W] = COEF_W'($urandom);
      endcase
    end
    return k;
  endfunction

  function automatic void push_pixel(logic signed [PIX_W-1:0] p);
    pixel_queue.push_back(p);
    pixels_pushed++;
  endfunction

  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [63:0] value);
    logic [APB_DATA_W-1:0] data;
    data = $urandom_range(0, 1) ? {$urandom, $urandom} : '0;
    case (idx)
      REG_FRAME_WIDTH:  data[FRAME_WIDTH_W-1:0]  = value[FRAME_WIDTH_W-1:0];
      REG_FRAME_HEIGHT: data[FRAME_HEIGHT_W-1:0] = value[FRAME_HEIGHT_W-1:0];
      default:          data[KERNEL_ROW_W-1:0]   = value[KERNEL_ROW_W-1:0];
    endcase
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_FRAME_WIDTH:  cfg_width     = data[FRAME_WIDTH_W-1:0];
      REG_FRAME_HEIGHT: cfg_height    = data[FRAME_HEIGHT_W-1:0];
      REG_KERNEL_TOP:   cfg_kernel[0] = data[KERNEL_ROW_W-1:0];
      REG_KERNEL_MID:   cfg_kernel[1] = data[KERNEL_ROW_W-1:0];
      REG_KERNEL_BOT:   cfg_kernel[2] = data[KERNEL_ROW_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pixels_accepted != pixels_pushed || expected_results.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  // push the rest of the current frame, after clamping the position
  task automatic finish_frame();
    int w, h, c, r, n;
    w = eff_width();
    h = eff_height();
    c = (col_pos >= w) ? w - 1 : col_pos;
    r = (row_pos >= h) ? h - 1 : row_pos;
    n = w * (h - 1 - r) + (w - c);
    repeat (n) push_pixel(rand_pixel());
  endtask

  task automatic write_kernels();
    reg_write(REG_KERNEL_TOP, rand_kernel());
    reg_write(REG_KERNEL_MID, rand_kernel());
    reg_write(REG_KERNEL_BOT, rand_kernel());
  endtask

  always @(posedge clk) begin
    filt_result_t want;
    pix_taken = 1'b0;
    if (!rst) begin
      if (in_valid && in_ready) begin
        filter_pixel(pixel_in);
        pix_taken = 1'b1;
        pixels_accepted++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (frame_end) frames_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual value %0d frame_end %0b",
                   $time, filtered_value, frame_end);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (filtered_value !== want.value) begin
            $display("%0t: filtered_value mismatch: expected %0d, actual %0d",
                     $time, want.value, filtered_value);
            error_count++;
          end
          if (frame_end !== want.last) begin
            $display("%0t: frame_end mismatch: expected %0b, actual %0b",
                     $time, want.last, frame_end);
            error_count++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else if (!in_valid || pix_taken) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (pixel_queue.size() != 0) begin
        in_valid <= 1'b1;
        pixel_in <= pixel_queue.pop_front();
        in_gap   <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall <= out_stall - 1;
    end else begin
      out_ready <= 1'b1;
      if (!burst_mode && $urandom_range(0, 99) < 20) out_stall <= pick_gap();
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run stalled, cycle limit %0d reached", $time, CYCLE_LIMIT);
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    int w, h, k, start_count;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset sizes and kernel (1.0 on the middle-row left tap), then shrink both sizes mid-row
    push_pixel(16'sh7FFF);
    push_pixel(16'sh8000);
    push_pixel(16'sh0000);
    push_pixel(16'shFFFF);
    push_pixel(16'sh1234);
    wait_idle();
    reg_write(REG_FRAME_WIDTH, 3);
    reg_write(REG_FRAME_HEIGHT, 2);
    finish_frame();
    wait_idle();

    // zero sizes act as a single pixel frame
    reg_write(REG_FRAME_WIDTH, 0);
    reg_write(REG_FRAME_HEIGHT, 0);
    reg_write(REG_KERNEL_MID, 48'h8000_8000_8000);
    push_pixel(16'sh8000);
    push_pixel(16'sh7FFF);
    wait_idle();

    // largest magnitude sums
    reg_write(REG_FRAME_WIDTH, 3);
    reg_write(REG_FRAME_HEIGHT, 3);
    reg_write(REG_KERNEL_TOP, 48'h8000_8000_8000);
    reg_write(REG_KERNEL_BOT, 48'h8000_8000_8000);
    repeat (9) push_pixel(16'sh8000);
    wait_idle();

    // negative fractions truncate toward zero
    reg_write(REG_FRAME_WIDTH, 2);
    reg_write(REG_FRAME_HEIGHT, 2);
    reg_write(REG_KERNEL_TOP, 48'h7FFF_7FFF_7FFF);
    reg_write(REG_KERNEL_MID, 48'h7FFF_0001_FFFF);
    reg_write(REG_KERNEL_BOT, 48'h0100_7FFF_8001);
    push_pixel(16'sh7FFF);
    push_pixel(16'sh8000);
    push_pixel(16'shFFFF);
    push_pixel(16'sh0001);
    wait_idle();

    // oversized registers clamp, then shrink to close the frame early
    reg_write(REG_FRAME_WIDTH, 2047);
    reg_write(REG_FRAME_HEIGHT, 511);
    write_kernels();
    repeat (12) push_pixel(rand_pixel());
    wait_idle();
    reg_write(REG_FRAME_WIDTH, 4);
    reg_write(REG_FRAME_HEIGHT, 3);
    finish_frame();
    wait_idle();
    reg_write(REG_FRAME_WIDTH, 1);
    reg_write(REG_FRAME_HEIGHT, 511);
    write_kernels();
    repeat (10) push_pixel(rand_pixel());
    wait_idle();
    reg_write(REG_FRAME_HEIGHT, 12);
    finish_frame();
    wait_idle();

    start_count = pixels_pushed;
    while (pixels_pushed - start_count < RANDOM_ITEMS) begin
      burst_mode = ($urandom_range(0, 3) == 0);
      w = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(0, 12);
      h = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(0, 8);
      reg_write(REG_FRAME_WIDTH, w);
      reg_write(REG_FRAME_HEIGHT, h);
      if ($urandom_range(0, 2) == 0) write_kernels();
      if (eff_width() * eff_height() >= 2 && $urandom_range(0, 2) == 0) begin
        k = $urandom_range(1, eff_width() * eff_height() - 1);
        repeat (k) push_pixel(rand_pixel());
        wait_idle();
        // shrink only, so every line entry read was written this frame
        if ($urandom_range(0, 1)) reg_write(REG_FRAME_WIDTH, $urandom_range(1, eff_width()));
        if ($urandom_range(0, 1)) reg_write(REG_FRAME_HEIGHT, $urandom_range(1, eff_height()));
        if ($urandom_range(0, 1)) reg_write(REG_KERNEL_MID, rand_kernel());
      end
      finish_frame();
      wait_idle();
    end
    burst_mode = 1'b0;
    wait_idle();

    $display("Run covered %0d pixel transactions, %0d results over %0d frames, %0d register writes.",
             pixels_accepted, results_seen, frames_seen, reg_writes);
    $display("Frames ranged from one pixel to oversized sizes cut short, with mid-frame shrinks.");
    if (error_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
